// ----- src/mmbp_pkg.sv -----
package mmbp_pkg;

	localparam int unsigned MaxBlocksDefault = 65536;

	// register indexes
	localparam logic [2:0] REG_PRED_OP     = 3'd0;
	localparam logic [2:0] REG_PRED_VALUE  = 3'd1;
	localparam logic [2:0] REG_VALUE_TYPE  = 3'd2;
	localparam logic [2:0] REG_BOX_DIMS    = 3'd3;
	localparam logic [2:0] REG_BOX_START_X = 3'd4;
	localparam logic [2:0] REG_BOX_COUNT_X = 3'd5;
	localparam logic [2:0] REG_BOX_START_Y = 3'd6;
	localparam logic [2:0] REG_BOX_COUNT_Y = 3'd7;

	// predicate codes
	localparam logic [2:0] OP_LT = 3'd0;
	localparam logic [2:0] OP_LE = 3'd1;
	localparam logic [2:0] OP_GT = 3'd2;
	localparam logic [2:0] OP_GE = 3'd3;
	localparam logic [2:0] OP_EQ = 3'd4;
	localparam logic [2:0] OP_NE = 3'd5;

	// value types
	localparam logic [1:0] VT_UNSIGNED = 2'd0;
	localparam logic [1:0] VT_SIGNED   = 2'd1;
	localparam logic [1:0] VT_DOUBLE   = 2'd2;

	typedef struct packed {
		logic [2:0]  pred_op;
		logic [63:0] pred_value;
		logic [1:0]  value_type;
		logic [1:0]  box_dims;
		logic [31:0] box_start_x;
		logic [31:0] box_count_x;
		logic [31:0] box_start_y;
		logic [31:0] box_count_y;
	} cfg_t;

	// comparison flags of pred against a statistic
	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
	} cmp_t;

endpackage

// ----- src/mmbp_cmp.sv -----
module mmbp_cmp
	import mmbp_pkg::*;
(
	input  logic [63:0] pred,
	input  logic [63:0] stat,
	input  logic [1:0]  value_type,
	output cmp_t        res
);

	logic a_nan, b_nan, both_zero, a_neg, b_neg, mag_lt, mag_eq;
	logic [63:0] pb, sb;

	assign a_nan = (pred[62:52] == 11'h7FF) && (pred[51:0] != 52'd0);
	assign b_nan = (stat[62:52] == 11'h7FF) && (stat[51:0] != 52'd0);
	assign both_zero = (pred[62:0] == 63'd0) && (stat[62:0] == 63'd0);
	assign a_neg = pred[63];
	assign b_neg = stat[63];
	assign mag_lt = pred[62:0] < stat[62:0];
	assign mag_eq = pred[62:0] == stat[62:0];
	assign pb = pred ^ {1'b1, 63'd0};
	assign sb = stat ^ {1'b1, 63'd0};

	// ordering per value type; unused type and NaN give all false
	always_comb begin
		res = '0;
		case (value_type)
			VT_UNSIGNED: begin
				res.lt = pred < stat;
				res.eq = pred == stat;
				res.gt = pred > stat;
			end
			VT_SIGNED: begin
				res.lt = pb < sb;
				res.eq = pb == sb;
				res.gt = pb > sb;
			end
			VT_DOUBLE: begin
				if (!a_nan && !b_nan) begin
					if (both_zero) begin
						res.eq = 1'b1;
					end else if (a_neg != b_neg) begin
						res.lt = a_neg;
						res.gt = b_neg;
					end else begin
						res.eq = mag_eq;
						res.lt = a_neg ? (!mag_lt && !mag_eq) : mag_lt;
						res.gt = !mag_eq && !res.lt;
					end
				end
			end
			default: res = '0;
		endcase
	end

endmodule

// ----- src/mmbp_eval.sv -----
module mmbp_eval
	import mmbp_pkg::*;
(
	input  cfg_t        cfg,
	input  logic [63:0] block_min,
	input  logic [63:0] block_max,
	input  logic [31:0] block_start_x,
	input  logic [31:0] block_count_x,
	input  logic [31:0] block_start_y,
	input  logic [31:0] block_count_y,
	input  logic        in_play,
	output logic        match
);

	cmp_t c_min, c_max;
	logic miss_x, miss_y, box_ok, range_ok;

	mmbp_cmp u_cmp_min (
		.pred(cfg.pred_value), .stat(block_min), .value_type(cfg.value_type), .res(c_min)
	);
	mmbp_cmp u_cmp_max (
		.pred(cfg.pred_value), .stat(block_max), .value_type(cfg.value_type), .res(c_max)
	);

	// box overlap at 33 bits
	assign miss_x = ({1'b0, block_start_x} + {1'b0, block_count_x} <= {1'b0, cfg.box_start_x})
		|| ({1'b0, cfg.box_start_x} + {1'b0, cfg.box_count_x} <= {1'b0, block_start_x});
	assign miss_y = ({1'b0, block_start_y} + {1'b0, block_count_y} <= {1'b0, cfg.box_start_y})
		|| ({1'b0, cfg.box_start_y} + {1'b0, cfg.box_count_y} <= {1'b0, block_start_y});
	assign box_ok = !((cfg.box_dims != 2'd0) && miss_x)
		&& !((cfg.box_dims >= 2'd2) && miss_y);

	// range test
	always_comb begin
		case (cfg.pred_op)
			OP_LT:   range_ok = c_min.gt;
			OP_LE:   range_ok = c_min.gt || c_min.eq;
			OP_GT:   range_ok = c_max.lt;
			OP_GE:   range_ok = c_max.lt || c_max.eq;
			OP_EQ:   range_ok = (c_min.gt || c_min.eq) && (c_max.lt || c_max.eq);
			OP_NE:   range_ok = !(c_min.eq && c_max.eq);
			default: range_ok = 1'b1;
		endcase
	end

	assign match = in_play && box_ok && range_ok;

endmodule

// ----- src/minmax_block_pruning_filter.sv -----
// An accepted beat passes the input register, then the result register.
// Throughput: one block per cycle unless m_tready stalls the output, set by
//   the single input register stage and the single result register; the
//   output register frees on take. Reset: arst_n asynchronous active low
//   clears counters, valid flags and all configuration registers to zero.
module minmax_block_pruning_filter
	import mmbp_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = MaxBlocksDefault
)(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// block_min, block_max, block_start_x, block_count_x, block_start_y,
	// block_count_y, in_play, zero fill
	input  logic [263:0] s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// block_match, block_number, match_total, zero fill
	output logic [39:0]  m_tdata,
	output logic         m_tlast
);

	localparam logic [15:0] BlkLimit = (MAX_BLOCKS - 1 > 65535) ? 16'hFFFF
		: 16'(MAX_BLOCKS - 1);

	cfg_t cfg_q;
	logic v_s1, v_s2;
	logic [256:0] d_s1;
	logic last_s1;
	logic match;
	logic [15:0] blk_q;
	logic [16:0] mcnt_q, total;
	logic adv_s2, adv_s1;
	logic match_s2, last_s2;
	logic [15:0] num_s2;
	logic [16:0] tot_s2;

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PRED_OP:     cfg_q.pred_op <= cfg_data[2:0];
				REG_PRED_VALUE:  cfg_q.pred_value <= cfg_data;
				REG_VALUE_TYPE:  cfg_q.value_type <= cfg_data[1:0];
				REG_BOX_DIMS:    cfg_q.box_dims <= cfg_data[1:0];
				REG_BOX_START_X: cfg_q.box_start_x <= cfg_data[31:0];
				REG_BOX_COUNT_X: cfg_q.box_count_x <= cfg_data[31:0];
				REG_BOX_START_Y: cfg_q.box_start_y <= cfg_data[31:0];
				REG_BOX_COUNT_Y: cfg_q.box_count_y <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign adv_s2 = !v_s2 || m_tready;
	assign adv_s1 = !v_s1 || adv_s2;
	assign s_tready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			d_s1 <= s_tdata[256:0];
			last_s1 <= s_tlast;
		end
	end

	mmbp_eval u_eval (
		.cfg(cfg_q),
		.block_min(d_s1[63:0]),
		.block_max(d_s1[127:64]),
		.block_start_x(d_s1[159:128]),
		.block_count_x(d_s1[191:160]),
		.block_start_y(d_s1[223:192]),
		.block_count_y(d_s1[255:224]),
		.in_play(d_s1[256]),
		.match(match)
	);

	assign total = (match && mcnt_q != 17'h1FFFF) ? mcnt_q + 17'd1 : mcnt_q;

	// counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			blk_q <= '0;
			mcnt_q <= '0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				if (last_s1) begin
					blk_q <= '0;
					mcnt_q <= '0;
				end else begin
					if (blk_q < BlkLimit) blk_q <= blk_q + 16'd1;
					mcnt_q <= total;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			match_s2 <= match;
			num_s2 <= blk_q;
			tot_s2 <= total;
			last_s2 <= last_s1;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata = {6'd0, tot_s2, num_s2, match_s2};
	assign m_tlast = last_s2;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !m_tready |=> v_s2) else $error("result dropped");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready) else $error("ready low with empty stage");
	a_lim: assert property (@(posedge clk) disable iff (!arst_n)
		blk_q <= BlkLimit) else $error("block counter past limit");

endmodule
